### rtl/core/lcse_pkg.sv
// Shared types, codes and constants of the link cable sync exchange block.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package lcse_pkg;

   typedef enum logic [1:0] {
      SYNC_READY  = 2'd0,
      SYNC_SENT1  = 2'd1,
      SYNC_QUEUED = 2'd2
   } sync_state_type;

   typedef enum logic {
      PHASE_FIRST  = 1'b0,
      PHASE_SECOND = 1'b1
   } phase_type;

   localparam logic [2:0] CMD_SYNC1    = 3'd2;
   localparam logic [2:0] CMD_SYNC2    = 3'd3;
   localparam logic [2:0] CMD_SYNC3    = 3'd4;
   localparam logic [2:0] CMD_RESERVED = 3'd7;

   localparam logic [1:0] ACT_SEND      = 2'd0;
   localparam logic [1:0] ACT_NOTIFY    = 2'd1;
   localparam logic [1:0] ACT_LOCAL_ERR = 2'd2;
   localparam logic [1:0] ACT_PEER_WARN = 2'd3;

   localparam logic [1:0] CSR_HIGH_SPEED   = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_SPEED = 2'd1;
   localparam logic [1:0] CSR_ACTIVE       = 2'd2;

   localparam logic [7:0] HIGH_SPEED_RESET   = 8'd2;
   localparam logic [7:0] DOUBLE_SPEED_RESET = 8'd4;
   localparam logic [7:0] ACTIVE_RESET       = 8'd1;

   localparam logic [7:0] SYNC3_ACK_BYTE = 8'd1;

   typedef struct packed {
      logic [7:0] high_speed;
      logic [7:0] double_speed;
      logic [7:0] active;
   } mask_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  command;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [31:0] stamp;
      logic        fast_flag;
      logic        double_flag;
      logic        passive_flag;
   } rsp_type;

   typedef struct packed {
      logic [7:0] byte2;
      logic       fast_flag;
      logic       double_flag;
      logic       passive_flag;
   } notify_type;

   typedef struct packed {
      rsp_type    first;
      logic       has_second;
      notify_type second;
   } job_type;

endpackage

### rtl/core/lcse_fifo.sv
// Short job queue between the packet classifier and the result sequencer.
// Depends on lcse_pkg for the job type.
`timescale 1ns / 1ps

module lcse_fifo #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcse_pkg::job_type push_job,
   input  logic              pop,
   output lcse_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   lcse_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/lcse_front.sv
// Packet classifier: accepts link packets, runs the sync state machine,
// holds the queued SYNC2 and queues jobs for results due. Uses lcse_pkg.
`timescale 1ns / 1ps

module lcse_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_incoming,
   input  logic [2:0]          req_command,
   input  logic [7:0]          req_byte2,
   input  logic [7:0]          req_byte3,
   input  logic [7:0]          req_byte4,
   input  logic [31:0]         req_stamp,
   input  lcse_pkg::mask_type  masks,
   input  logic                q_full,
   output logic                q_push,
   output lcse_pkg::job_type   q_job
);

   typedef struct packed {
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [31:0] stamp;
   } held_type;

   lcse_pkg::sync_state_type state_ff, state_in;
   held_type                 held_ff;
   logic                     hold_we;
   logic                     accept;
   logic                     active_cmd;
   lcse_pkg::notify_type     note;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign active_cmd = accept && (req_command != lcse_pkg::CMD_RESERVED);

   assign note.byte2        = req_byte2;
   assign note.fast_flag    = |(req_byte3 & masks.high_speed);
   assign note.double_flag  = |(req_byte3 & masks.double_speed);
   assign note.passive_flag = |(req_byte3 & masks.active);

   always_comb begin
      state_in = state_ff;
      if (active_cmd) begin
         unique case (state_ff)
            lcse_pkg::SYNC_SENT1: begin
               if (req_incoming) begin
                  state_in = lcse_pkg::SYNC_READY;
               end
            end
            default: begin
               priority if (state_ff == lcse_pkg::SYNC_QUEUED && req_incoming) begin
                  state_in = (req_command == lcse_pkg::CMD_SYNC1) ?
                             lcse_pkg::SYNC_READY : lcse_pkg::SYNC_QUEUED;
               end else if (!req_incoming && req_command == lcse_pkg::CMD_SYNC2) begin
                  state_in = lcse_pkg::SYNC_QUEUED;
               end else if (!req_incoming && req_command == lcse_pkg::CMD_SYNC1) begin
                  state_in = lcse_pkg::SYNC_SENT1;
               end else begin
                  state_in = lcse_pkg::SYNC_READY;
               end
            end
         endcase
      end
   end

   always_comb begin
      q_push  = 1'b0;
      q_job   = '0;
      hold_we = 1'b0;
      if (active_cmd) begin
         unique case (state_ff)
            lcse_pkg::SYNC_SENT1: begin
               q_push = 1'b1;
               priority if (!req_incoming) begin
                  q_job.first.action = lcse_pkg::ACT_LOCAL_ERR;
               end else if (req_command == lcse_pkg::CMD_SYNC2) begin
                  q_job.first.action       = lcse_pkg::ACT_NOTIFY;
                  q_job.first.byte2        = note.byte2;
                  q_job.first.fast_flag    = note.fast_flag;
                  q_job.first.double_flag  = note.double_flag;
                  q_job.first.passive_flag = note.passive_flag;
               end else if (req_command == lcse_pkg::CMD_SYNC3
                            && req_byte2 == lcse_pkg::SYNC3_ACK_BYTE) begin
                  q_push = 1'b0;
               end else begin
                  q_job.first.action = lcse_pkg::ACT_PEER_WARN;
               end
            end
            default: begin
               priority if (state_ff == lcse_pkg::SYNC_QUEUED && req_incoming
                            && req_command == lcse_pkg::CMD_SYNC1) begin
                  q_push               = 1'b1;
                  q_job.first.action   = lcse_pkg::ACT_SEND;
                  q_job.first.command  = lcse_pkg::CMD_SYNC2;
                  q_job.first.byte2    = held_ff.byte2;
                  q_job.first.byte3    = held_ff.byte3;
                  q_job.first.byte4    = held_ff.byte4;
                  q_job.first.stamp    = held_ff.stamp;
                  q_job.has_second     = 1'b1;
                  q_job.second         = note;
               end else if (!req_incoming) begin
                  if (req_command == lcse_pkg::CMD_SYNC2) begin
                     hold_we = 1'b1;
                  end else begin
                     q_push              = 1'b1;
                     q_job.first.action  = lcse_pkg::ACT_SEND;
                     q_job.first.command = req_command;
                     q_job.first.byte2   = req_byte2;
                     q_job.first.byte3   = req_byte3;
                     q_job.first.byte4   = req_byte4;
                     q_job.first.stamp   = req_stamp;
                  end
               end else if (req_command == lcse_pkg::CMD_SYNC2) begin
                  q_push             = 1'b1;
                  q_job.first.action = lcse_pkg::ACT_PEER_WARN;
               end else if (req_command == lcse_pkg::CMD_SYNC1) begin
                  q_push              = 1'b1;
                  q_job.first.action  = lcse_pkg::ACT_SEND;
                  q_job.first.command = lcse_pkg::CMD_SYNC3;
                  q_job.first.byte2   = lcse_pkg::SYNC3_ACK_BYTE;
                  q_job.has_second    = 1'b1;
                  q_job.second        = note;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcse_pkg::SYNC_READY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_we) begin
         held_ff.byte2 <= req_byte2;
         held_ff.byte3 <= req_byte3;
         held_ff.byte4 <= req_byte4;
         held_ff.stamp <= req_stamp;
      end
   end

endmodule

### rtl/core/lcse_back.sv
// Result sequencer: takes jobs from the queue and issues one or two results
// each through a registered output stage. Uses lcse_pkg.
`timescale 1ns / 1ps

module lcse_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  lcse_pkg::job_type  q_job,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lcse_pkg::rsp_type  rsp,
   output logic               rsp_last
);

   lcse_pkg::phase_type phase_ff, phase_in;
   logic                valid_ff, valid_in;
   lcse_pkg::rsp_type   rsp_ff, rsp_in;
   logic                last_ff, last_in;
   logic                load;
   logic                take;
   lcse_pkg::rsp_type   second_rsp;

   assign load = !valid_ff || !rsp_stall;
   assign take = load && !q_empty;

   always_comb begin
      second_rsp              = '0;
      second_rsp.action       = lcse_pkg::ACT_NOTIFY;
      second_rsp.byte2        = q_job.second.byte2;
      second_rsp.fast_flag    = q_job.second.fast_flag;
      second_rsp.double_flag  = q_job.second.double_flag;
      second_rsp.passive_flag = q_job.second.passive_flag;
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            lcse_pkg::PHASE_FIRST:
               phase_in = q_job.has_second ? lcse_pkg::PHASE_SECOND : lcse_pkg::PHASE_FIRST;
            lcse_pkg::PHASE_SECOND:
               phase_in = lcse_pkg::PHASE_FIRST;
         endcase
      end
   end

   always_comb begin
      unique case (phase_ff)
         lcse_pkg::PHASE_FIRST: begin
            rsp_in  = q_job.first;
            last_in = !q_job.has_second;
         end
         lcse_pkg::PHASE_SECOND: begin
            rsp_in  = second_rsp;
            last_in = 1'b1;
         end
      endcase
      q_pop    = take && last_in;
      valid_in = take || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lcse_pkg::PHASE_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff  <= rsp_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;
   assign rsp_last  = last_ff;

endmodule

### rtl/core/link_cable_sync_exchange_fsm.sv
// Top level of the link cable sync exchange block: mask registers, the
// classifier, the job queue and the result sequencer. Uses lcse_pkg.
//
//   Channel  Direction  Handshake             Content
//   req_     in         req_valid/req_stall   one link packet
//   rsp_     out        rsp_valid/rsp_stall   one result, rsp_last on the final one
//   csr_     in         csr_we                mask register write
//
// A packet is classified in the cycle of its transfer; its job then goes through the
// queue and the registered output stage to rsp_. One packet is taken every cycle
// while the queue has room. The sequencer issues one result per cycle while
// rsp_stall is low; a two-result job is popped with its second result. Synchronous
// reset clears the sync state, queue and output stage and loads the mask defaults.
`timescale 1ns / 1ps

module link_cable_sync_exchange_fsm #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_incoming,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,
   input  logic [7:0]  req_byte4,
   input  logic [31:0] req_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [2:0]  rsp_out_command,
   output logic [7:0]  rsp_out_byte2,
   output logic [7:0]  rsp_out_byte3,
   output logic [7:0]  rsp_out_byte4,
   output logic [31:0] rsp_out_stamp,
   output logic        rsp_fast_flag,
   output logic        rsp_double_flag,
   output logic        rsp_passive_flag,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   lcse_pkg::mask_type masks_ff, masks_in;
   lcse_pkg::job_type  push_job;
   lcse_pkg::job_type  head_job;
   lcse_pkg::rsp_type  rsp;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;

   always_comb begin
      masks_in = masks_ff;
      if (csr_we) begin
         unique case (csr_index)
            lcse_pkg::CSR_HIGH_SPEED:   masks_in.high_speed   = csr_wdata;
            lcse_pkg::CSR_DOUBLE_SPEED: masks_in.double_speed = csr_wdata;
            lcse_pkg::CSR_ACTIVE:       masks_in.active       = csr_wdata;
            default:                    masks_in = masks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff.high_speed   <= lcse_pkg::HIGH_SPEED_RESET;
         masks_ff.double_speed <= lcse_pkg::DOUBLE_SPEED_RESET;
         masks_ff.active       <= lcse_pkg::ACTIVE_RESET;
      end else begin
         masks_ff <= masks_in;
      end
   end

   lcse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_incoming (req_incoming),
      .req_command  (req_command),
      .req_byte2    (req_byte2),
      .req_byte3    (req_byte3),
      .req_byte4    (req_byte4),
      .req_stamp    (req_stamp),
      .masks        (masks_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (push_job)
   );

   lcse_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   lcse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .rsp_last  (rsp_last)
   );

   assign rsp_action       = rsp.action;
   assign rsp_out_command  = rsp.command;
   assign rsp_out_byte2    = rsp.byte2;
   assign rsp_out_byte3    = rsp.byte3;
   assign rsp_out_byte4    = rsp.byte4;
   assign rsp_out_stamp    = rsp.stamp;
   assign rsp_fast_flag    = rsp.fast_flag;
   assign rsp_double_flag  = rsp.double_flag;
   assign rsp_passive_flag = rsp.passive_flag;

`ifndef ASSERT_OFF
   a_first_of_pair_is_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_action == lcse_pkg::ACT_SEND)
      else $error("first of two results is not a send");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("second result of a pair not issued in the next cycle");

   a_flags_only_on_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != lcse_pkg::ACT_NOTIFY
      |-> !rsp_fast_flag && !rsp_double_flag && !rsp_passive_flag)
      else $error("speed flags set on a result that is not a notify");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == lcse_pkg::ACT_LOCAL_ERR
                    || rsp_action == lcse_pkg::ACT_PEER_WARN)
      |-> rsp_out_command == 3'd0 && rsp_out_byte2 == 8'd0 && rsp_out_stamp == 32'd0)
      else $error("error result carries packet data");
`endif

endmodule

### dv/tb_link_cable_sync_exchange_fsm.sv
// Self-checking testbench for link_cable_sync_exchange_fsm: directed and random
// link packets under several mask settings, with a scoreboard class predicting
// every result. Depends on lcse_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb_link_cable_sync_exchange_fsm;

   localparam logic [2:0] CMD_VERSION         = 3'd0;
   localparam logic [2:0] CMD_JOYPAD          = 3'd1;
   localparam logic [2:0] CMD_STATUS          = 3'd5;
   localparam logic [2:0] CMD_WANT_DISCONNECT = 3'd6;
   localparam logic [1:0] CSR_SPARE           = 2'd3;
   localparam logic       OUTGOING            = 1'b0;
   localparam logic       INCOMING            = 1'b1;

   localparam int RANDOM_PACKETS = 750;
   localparam int MASK_PHASES    = 5;
   localparam int SETTLE_CYCLES  = 8;
   localparam int QUIET_LIMIT    = 2000;
   localparam int IDLE_PERCENT   = 24;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      lcse_pkg::rsp_type fields;
      logic              last;
   } link_result_type;

   typedef struct packed {
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [31:0] stamp;
   } held_packet_type;

   class sync_exchange_scoreboard;
      logic [7:0]               high_speed_mask;
      logic [7:0]               double_speed_mask;
      logic [7:0]               active_mask;
      lcse_pkg::sync_state_type link_state;
      held_packet_type          held_sync2;
      link_result_type          awaited_results[$];
      int                       mismatches;
      int                       results_checked;
      int                       packets_noted;
      int                       action_count[4];

      function void restart();
         high_speed_mask   = lcse_pkg::HIGH_SPEED_RESET;
         double_speed_mask = lcse_pkg::DOUBLE_SPEED_RESET;
         active_mask       = lcse_pkg::ACTIVE_RESET;
         link_state        = lcse_pkg::SYNC_READY;
         held_sync2        = '0;
         awaited_results.delete();
         mismatches      = 0;
         results_checked = 0;
         packets_noted   = 0;
         foreach (action_count[i]) action_count[i] = 0;
      endfunction

      function void write_mask(logic [1:0] index, logic [7:0] value);
         case (index)
            lcse_pkg::CSR_HIGH_SPEED:   high_speed_mask = value;
            lcse_pkg::CSR_DOUBLE_SPEED: double_speed_mask = value;
            lcse_pkg::CSR_ACTIVE:       active_mask = value;
            default: ;
         endcase
      endfunction

      function lcse_pkg::rsp_type send_result(logic [2:0] command, logic [7:0] byte2,
                                              logic [7:0] byte3, logic [7:0] byte4,
                                              logic [31:0] stamp);
         lcse_pkg::rsp_type r;
         r = '0;
         r.action  = lcse_pkg::ACT_SEND;
         r.command = command;
         r.byte2   = byte2;
         r.byte3   = byte3;
         r.byte4   = byte4;
         r.stamp   = stamp;
         return r;
      endfunction

      function lcse_pkg::rsp_type notify_result(logic [7:0] byte2, logic [7:0] byte3);
         lcse_pkg::rsp_type r;
         r = '0;
         r.action       = lcse_pkg::ACT_NOTIFY;
         r.byte2        = byte2;
         r.fast_flag    = |(byte3 & high_speed_mask);
         r.double_flag  = |(byte3 & double_speed_mask);
         r.passive_flag = |(byte3 & active_mask);
         return r;
      endfunction

      function lcse_pkg::rsp_type flag_result(logic [1:0] action);
         lcse_pkg::rsp_type r;
         r = '0;
         r.action = action;
         return r;
      endfunction

      function void note_packet(logic incoming, logic [2:0] command, logic [7:0] byte2,
                                logic [7:0] byte3, logic [7:0] byte4, logic [31:0] stamp);
         lcse_pkg::rsp_type caused[$];
         logic              keep_queued;
         link_result_type   entry;
         packets_noted++;
         if (command == lcse_pkg::CMD_RESERVED) return;
         if (link_state == lcse_pkg::SYNC_SENT1) begin
            if (!incoming) begin
               caused.insert(caused.size(), flag_result(lcse_pkg::ACT_LOCAL_ERR));
            end else begin
               if (command == lcse_pkg::CMD_SYNC2) begin
                  caused.insert(caused.size(), notify_result(byte2, byte3));
               end else if (!(command == lcse_pkg::CMD_SYNC3
                              && byte2 == lcse_pkg::SYNC3_ACK_BYTE)) begin
                  caused.insert(caused.size(), flag_result(lcse_pkg::ACT_PEER_WARN));
               end
               link_state = lcse_pkg::SYNC_READY;
            end
         end else if (link_state == lcse_pkg::SYNC_QUEUED && incoming
                      && command == lcse_pkg::CMD_SYNC1) begin
            caused.insert(caused.size(),
                          send_result(lcse_pkg::CMD_SYNC2, held_sync2.byte2,
                                      held_sync2.byte3, held_sync2.byte4,
                                      held_sync2.stamp));
            caused.insert(caused.size(), notify_result(byte2, byte3));
            link_state = lcse_pkg::SYNC_READY;
         end else begin
            keep_queued = (link_state == lcse_pkg::SYNC_QUEUED) && incoming;
            link_state = lcse_pkg::SYNC_READY;
            if (!incoming) begin
               if (command == lcse_pkg::CMD_SYNC2) begin
                  held_sync2 = '{byte2: byte2, byte3: byte3, byte4: byte4, stamp: stamp};
                  link_state = lcse_pkg::SYNC_QUEUED;
               end else begin
                  if (command == lcse_pkg::CMD_SYNC1) link_state = lcse_pkg::SYNC_SENT1;
                  caused.insert(caused.size(),
                                send_result(command, byte2, byte3, byte4, stamp));
               end
            end else if (command == lcse_pkg::CMD_SYNC2) begin
               caused.insert(caused.size(), flag_result(lcse_pkg::ACT_PEER_WARN));
            end else if (command == lcse_pkg::CMD_SYNC1) begin
               caused.insert(caused.size(),
                             send_result(lcse_pkg::CMD_SYNC3, lcse_pkg::SYNC3_ACK_BYTE,
                                         '0, '0, '0));
               caused.insert(caused.size(), notify_result(byte2, byte3));
            end
            if (keep_queued) link_state = lcse_pkg::SYNC_QUEUED;
         end
         foreach (caused[i]) begin
            entry.fields = caused[i];
            entry.last   = (i == caused.size() - 1);
            awaited_results.insert(awaited_results.size(), entry);
         end
      endfunction

      function string describe(link_result_type r);
         return $sformatf({"action %0d cmd %0d b2 %02h b3 %02h b4 %02h stamp %08h",
                           " fast %b double %b passive %b last %b"},
                          r.fields.action, r.fields.command, r.fields.byte2,
                          r.fields.byte3, r.fields.byte4, r.fields.stamp,
                          r.fields.fast_flag, r.fields.double_flag,
                          r.fields.passive_flag, r.last);
      endfunction

      function void check_result(link_result_type actual);
         link_result_type awaited;
         results_checked++;
         action_count[actual.fields.action]++;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Result with none awaited: %s", describe(actual));
            return;
         end
         awaited = awaited_results.pop_front();
         if (actual !== awaited) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Mismatch on result %0d", results_checked);
               $display("   expected %s", describe(awaited));
               $display("   actual   %s", describe(actual));
            end
         end
      endfunction

      function bit failed();
         return mismatches != 0 || awaited_results.size() != 0;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_incoming = 1'b0;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_byte2 = '0;
   logic [7:0]  req_byte3 = '0;
   logic [7:0]  req_byte4 = '0;
   logic [31:0] req_stamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic [2:0]  rsp_out_command;
   logic [7:0]  rsp_out_byte2;
   logic [7:0]  rsp_out_byte3;
   logic [7:0]  rsp_out_byte4;
   logic [31:0] rsp_out_stamp;
   logic        rsp_fast_flag;
   logic        rsp_double_flag;
   logic        rsp_passive_flag;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = lcse_pkg::CSR_HIGH_SPEED;
   logic [7:0]  csr_wdata = '0;

   sync_exchange_scoreboard exchange_board;
   link_result_type         observed;
   bit                      no_idle = 1'b0;
   int                      packets_sent = 0;
   int                      quiet_cycles = 0;

   link_cable_sync_exchange_fsm u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_incoming    (req_incoming),
      .req_command     (req_command),
      .req_byte2       (req_byte2),
      .req_byte3       (req_byte3),
      .req_byte4       (req_byte4),
      .req_stamp       (req_stamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_out_command (rsp_out_command),
      .rsp_out_byte2   (rsp_out_byte2),
      .rsp_out_byte3   (rsp_out_byte3),
      .rsp_out_byte4   (rsp_out_byte4),
      .rsp_out_stamp   (rsp_out_stamp),
      .rsp_fast_flag   (rsp_fast_flag),
      .rsp_double_flag (rsp_double_flag),
      .rsp_passive_flag(rsp_passive_flag),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.fields = '{action: rsp_action, command: rsp_out_command,
                             byte2: rsp_out_byte2, byte3: rsp_out_byte3,
                             byte4: rsp_out_byte4, stamp: rsp_out_stamp,
                             fast_flag: rsp_fast_flag, double_flag: rsp_double_flag,
                             passive_flag: rsp_passive_flag};
         observed.last = rsp_last;
         exchange_board.check_result(observed);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic drive_packet(logic incoming, logic [2:0] command, logic [7:0] byte2,
                               logic [7:0] byte3, logic [7:0] byte4, logic [31:0] stamp);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_incoming = incoming;
      req_command  = command;
      req_byte2    = byte2;
      req_byte3    = byte3;
      req_byte4    = byte4;
      req_stamp    = stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      exchange_board.note_packet(incoming, command, byte2, byte3, byte4, stamp);
      packets_sent++;
   endtask

   task automatic send_random(logic incoming, logic [2:0] command);
      drive_packet(incoming, command, 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (exchange_board.awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [7:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      exchange_board.write_mask(index, value);
   endtask

   task automatic load_masks(int phase);
      logic [7:0] values[3];
      foreach (values[i]) begin
         case (phase)
            1:       values[i] = 8'h00;
            2:       values[i] = 8'hff;
            3:       values[i] = 8'($urandom);
            default: values[i] = 8'd1 << $urandom_range(0, 7);
         endcase
      end
      write_register(lcse_pkg::CSR_HIGH_SPEED, values[0]);
      write_register(lcse_pkg::CSR_DOUBLE_SPEED, values[1]);
      write_register(lcse_pkg::CSR_ACTIVE, values[2]);
      write_register(CSR_SPARE, 8'($urandom));
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic run_directed();
      drive_packet(OUTGOING, CMD_VERSION, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(OUTGOING, CMD_JOYPAD, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(OUTGOING, CMD_STATUS, 8'h5a, 8'ha5, 8'h3c, 32'h1234_5678);
      drive_packet(OUTGOING, CMD_WANT_DISCONNECT, 8'h01, 8'h80, 8'h7f, 32'h8000_0001);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC3, 8'h01, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, CMD_VERSION, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(INCOMING, CMD_STATUS, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC3, 8'h01, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC2, 8'h33, 8'h07, 8'h00, 32'h0000_0010);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC1, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC1, 8'h42, 8'h81, 8'h00, 32'h0000_0100);
      drive_packet(OUTGOING, CMD_VERSION, 8'h11, 8'h22, 8'h33, 32'h4444_4444);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC2, 8'h99, 8'h02, 8'hee, 32'hdead_beef);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC1, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC3, 8'h01, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC1, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC3, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC1, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(INCOMING, lcse_pkg::CMD_RESERVED, 8'h01, 8'h01, 8'h01, 32'h0000_0001);
      drive_packet(INCOMING, CMD_JOYPAD, 8'h01, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC2, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(INCOMING, CMD_VERSION, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC2, 8'h12, 8'h34, 8'h56, 32'h789a_bcde);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC1, 8'h5a, 8'h04, 8'h00, 32'h0000_0000);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC2, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(OUTGOING, lcse_pkg::CMD_RESERVED, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
      drive_packet(OUTGOING, CMD_STATUS, 8'h0f, 8'hf0, 8'h0f, 32'h0f0f_0f0f);
      drive_packet(OUTGOING, lcse_pkg::CMD_SYNC2, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      drive_packet(INCOMING, lcse_pkg::CMD_SYNC1, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
   endtask

   task automatic run_random_sequence();
      case ($urandom_range(0, 9))
         0, 1: begin
            send_random(OUTGOING, lcse_pkg::CMD_SYNC1);
            case ($urandom_range(0, 3))
               0:       send_random(INCOMING, lcse_pkg::CMD_SYNC2);
               1:       drive_packet(INCOMING, lcse_pkg::CMD_SYNC3,
                                     lcse_pkg::SYNC3_ACK_BYTE, 8'($urandom),
                                     8'($urandom), $urandom);
               2:       send_random(INCOMING, lcse_pkg::CMD_SYNC3);
               default: send_random(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            endcase
         end
         2, 3: begin
            send_random(OUTGOING, lcse_pkg::CMD_SYNC2);
            if ($urandom_range(0, 2) == 0) send_random(INCOMING, 3'($urandom_range(0, 7)));
            send_random(INCOMING, lcse_pkg::CMD_SYNC1);
         end
         4: send_random(INCOMING, lcse_pkg::CMD_SYNC1);
         5: begin
            send_random(OUTGOING, lcse_pkg::CMD_SYNC2);
            send_random(OUTGOING, 3'($urandom_range(0, 7)));
         end
         6: send_random(OUTGOING, 3'($urandom_range(0, 7)));
         default: send_random(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      endcase
   endtask

   initial begin
      int target;
      exchange_board = new();
      exchange_board.restart();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      wait_drained();
      target = packets_sent;
      for (int phase = 0; phase < MASK_PHASES; phase++) begin
         if (phase != 0) load_masks(phase);
         no_idle = (phase == 2);
         target += RANDOM_PACKETS / MASK_PHASES;
         while (packets_sent < target) run_random_sequence();
         no_idle = 1'b0;
         wait_drained();
      end
      $display("Run covered %0d packets and %0d results: %0d sends, %0d notifies,",
               exchange_board.packets_noted, exchange_board.results_checked,
               exchange_board.action_count[lcse_pkg::ACT_SEND],
               exchange_board.action_count[lcse_pkg::ACT_NOTIFY]);
      $display("%0d local errors and %0d peer warnings over %0d mask settings.",
               exchange_board.action_count[lcse_pkg::ACT_LOCAL_ERR],
               exchange_board.action_count[lcse_pkg::ACT_PEER_WARN], MASK_PHASES);
      if (exchange_board.failed()) begin
         $display("%0d mismatches, %0d results still awaited",
                  exchange_board.mismatches, exchange_board.awaited_results.size());
         $display("FAILED: results differ");
      end else begin
         $display("PASSED: all results match");
      end
      $finish;
   end

endmodule

### link_cable_sync_exchange_fsm.f
rtl/core/lcse_pkg.sv
rtl/core/lcse_fifo.sv
rtl/core/lcse_front.sv
rtl/core/lcse_back.sv
rtl/core/link_cable_sync_exchange_fsm.sv
dv/tb_link_cable_sync_exchange_fsm.sv
